/* sv/ppvc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ppvc_pkg;

    localparam int CordicStagesDef = 16;
    localparam int AtanLen         = 24;
    localparam int SqrtSteps       = 21;
    localparam int RadW            = 42;
    localparam int RemW            = 23;
    localparam int RootW           = 21;
    localparam int XyW             = 36;
    localparam int ZW              = 28;
    localparam int DiffW           = 17;
    localparam int AddrW           = 2;
    localparam logic signed [ZW-1:0] HalfPiZ = 28'sd26353589;

    // register indexes
    localparam logic [AddrW-1:0] RegGainDistance = 2'd0;
    localparam logic [AddrW-1:0] RegGainBearing  = 2'd1;
    localparam logic [AddrW-1:0] RegGainHeading  = 2'd2;

    // data handed from cell to cell
    typedef struct packed {
        logic [RadW-1:0]         rad;
        logic [RemW-1:0]         rem;
        logic [RootW-1:0]        root;
        logic signed [XyW-1:0]   x;
        logic signed [XyW-1:0]   y;
        logic signed [ZW-1:0]    z;
        logic signed [DiffW-1:0] dth;
        logic                    zero;
    } t_cell;

    // arctangent table, units of 2^-24 rad
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] r;
        unique case (idx)
            0:  r = 28'sd13176795;
            1:  r = 28'sd7778716;
            2:  r = 28'sd4110060;
            3:  r = 28'sd2086331;
            4:  r = 28'sd1047214;
            5:  r = 28'sd524117;
            6:  r = 28'sd262123;
            7:  r = 28'sd131069;
            8:  r = 28'sd65536;
            9:  r = 28'sd32768;
            10: r = 28'sd16384;
            11: r = 28'sd8192;
            12: r = 28'sd4096;
            13: r = 28'sd2048;
            14: r = 28'sd1024;
            15: r = 28'sd512;
            16: r = 28'sd256;
            17: r = 28'sd128;
            18: r = 28'sd64;
            19: r = 28'sd32;
            20: r = 28'sd16;
            21: r = 28'sd8;
            22: r = 28'sd4;
            23: r = 28'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/ppvc_prep.sv */
`timescale 1ns / 1ps
`default_nettype none
module ppvc_prep (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic [95:0]          i_data,
    output ppvc_pkg::t_cell           o_cell
);

    localparam int DW = ppvc_pkg::DiffW;
    localparam int XW = ppvc_pkg::XyW;

    logic signed [DW-1:0]   r_dx, r_dy, r_dth;
    logic [2*DW-1:0]        r_sqx, r_sqy;
    logic signed [DW-1:0]   n_dx, n_dy, n_dth;
    logic signed [XW-1:0]   w_x, w_y;
    logic [2*DW-1:0]        w_sq;

    // differences
    assign n_dx  = DW'($signed(i_data[63:48])) - DW'($signed(i_data[15:0]));
    assign n_dy  = DW'($signed(i_data[79:64])) - DW'($signed(i_data[31:16]));
    assign n_dth = DW'($signed(i_data[95:80])) - DW'($signed(i_data[47:32]));

    // differences and squares registered
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx  <= n_dx;
            r_dy  <= n_dy;
            r_dth <= n_dth;
            r_sqx <= (2*DW)'(n_dx) * (2*DW)'(n_dx);
            r_sqy <= (2*DW)'(n_dy) * (2*DW)'(n_dy);
        end
    end

    // radicand and cordic pre-rotation into right half plane
    assign w_sq = r_sqx + r_sqy;
    assign w_x  = {{(XW-DW-16){r_dx[DW-1]}}, r_dx, 16'b0};
    assign w_y  = {{(XW-DW-16){r_dy[DW-1]}}, r_dy, 16'b0};

    always_comb begin
        o_cell.rad  = {w_sq, 8'b0};
        o_cell.rem  = '0;
        o_cell.root = '0;
        o_cell.dth  = r_dth;
        o_cell.zero = (r_dx == '0) && (r_dy == '0);
        o_cell.x    = w_x;
        o_cell.y    = w_y;
        o_cell.z    = '0;
        if (r_dx[DW-1]) begin
            if (!r_dy[DW-1]) begin
                o_cell.x = w_y;
                o_cell.y = -w_x;
                o_cell.z = ppvc_pkg::HalfPiZ;
            end else begin
                o_cell.x = -w_y;
                o_cell.y = w_x;
                o_cell.z = -ppvc_pkg::HalfPiZ;
            end
        end
    end

endmodule
`default_nettype wire

/* sv/ppvc_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module ppvc_cell #(
    parameter int IDX    = 0,
    parameter int STAGES = ppvc_pkg::CordicStagesDef
) (
    input  wire logic           i_clk,
    input  wire logic           i_en,
    input  ppvc_pkg::t_cell     i_cell,
    output ppvc_pkg::t_cell     o_cell
);

    localparam int RW = ppvc_pkg::RemW;
    localparam int TW = ppvc_pkg::RootW;
    localparam int NW = ppvc_pkg::RadW;
    localparam int XW = ppvc_pkg::XyW;
    localparam bit DoSqrt   = IDX < ppvc_pkg::SqrtSteps;
    localparam bit DoCordic = (IDX < STAGES) && (IDX < ppvc_pkg::AtanLen);

    ppvc_pkg::t_cell        r_cell, n_cell;
    logic [RW-1:0]          w_rem, w_trial;
    logic signed [XW-1:0]   w_xs, w_ys;

    // one root digit and one cordic rotation, each only where this cell's index is in range
    assign w_rem   = {i_cell.rem[RW-3:0], i_cell.rad[NW-1 -: 2]};
    assign w_trial = {i_cell.root, 2'b01};
    assign w_xs    = i_cell.x >>> IDX;
    assign w_ys    = i_cell.y >>> IDX;

    always_comb begin
        n_cell = i_cell;
        if (DoSqrt) begin
            n_cell.rad = {i_cell.rad[NW-3:0], 2'b00};
            if (w_rem >= w_trial) begin
                n_cell.rem  = w_rem - w_trial;
                n_cell.root = {i_cell.root[TW-2:0], 1'b1};
            end else begin
                n_cell.rem  = w_rem;
                n_cell.root = {i_cell.root[TW-2:0], 1'b0};
            end
        end
        if (DoCordic) begin
            if (!i_cell.y[XW-1]) begin
                n_cell.x = i_cell.x + w_ys;
                n_cell.y = i_cell.y - w_xs;
                n_cell.z = i_cell.z + ppvc_pkg::atan_entry(IDX);
            end else begin
                n_cell.x = i_cell.x - w_ys;
                n_cell.y = i_cell.y + w_xs;
                n_cell.z = i_cell.z - ppvc_pkg::atan_entry(IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule
`default_nettype wire

/* sv/ppvc_post.sv */
`timescale 1ns / 1ps
`default_nettype none
module ppvc_post (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  ppvc_pkg::t_cell          i_cell,
    input  wire logic signed [15:0]  i_gain_distance,
    input  wire logic signed [15:0]  i_gain_bearing,
    input  wire logic signed [15:0]  i_gain_heading,
    output logic [63:0]              o_data,
    output logic                     o_sat
);

    localparam int ZW = ppvc_pkg::ZW;

    logic signed [ZW-1:0]  w_zr;
    logic signed [17:0]    w_bearing, w_alpha, w_beta;
    logic signed [37:0]    r_pv;
    logic signed [33:0]    r_pa, r_ph;
    logic signed [38:0]    w_v;
    logic signed [34:0]    w_w;
    logic signed [31:0]    w_vc, w_wc;
    logic                  w_vs, w_ws;
    logic [63:0]           r_data;
    logic                  r_sat;

    // bearing rounded to q13; alpha and beta
    assign w_zr      = i_cell.z + ZW'(1024);
    assign w_bearing = i_cell.zero ? '0 : 18'(w_zr >>> 11);
    assign w_alpha   = w_bearing - 18'(i_cell.dth);
    assign w_beta    = -18'(i_cell.dth) - w_alpha;

    // gain products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pv <= 38'(i_gain_distance) * 38'($signed({1'b0, i_cell.root}));
            r_pa <= 34'(i_gain_bearing) * 34'(w_alpha);
            r_ph <= 34'(i_gain_heading) * 34'(w_beta);
        end
    end

    // round half up and clamp
    assign w_v = (39'(r_pv) + 39'sd128) >>> 8;
    assign w_w = (35'(r_pa) + 35'(r_ph) + 35'sd16) >>> 5;

    always_comb begin
        w_vs = (w_v > 39'sh7FFFFFFF) || (w_v < -39'sh80000000);
        w_ws = (w_w > 35'sh7FFFFFFF) || (w_w < -35'sh80000000);
        w_vc = w_v[38] ? 32'sh80000000 : 32'sh7FFFFFFF;
        w_wc = w_w[34] ? 32'sh80000000 : 32'sh7FFFFFFF;
        if (!w_vs) w_vc = w_v[31:0];
        if (!w_ws) w_wc = w_w[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= {w_wc, w_vc};
            r_sat  <= w_vs | w_ws;
        end
    end

    assign o_data = r_data;
    assign o_sat  = r_sat;

endmodule
`default_nettype wire

/* sv/polar_pose_velocity_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// channel   dir  width            content
// s_axis    in   tdata 96         pose pair, one request per item
// m_axis    out  tdata 64, user 1 velocities and clamp flag
// cfg       in   addr 2, data 16  gain registers
//
// one item per cycle while the pipe advances; a request passes through the input
// register, the row of cells (21 square-root digits and the cordic rotations
// share it), the product register and the output register, where it is offered
// the whole pipe advances when the output register is empty or taken
// synchronous active-low reset clears valids and loads the default gains
module polar_pose_velocity_controller #(
    parameter int CORDIC_STAGES = ppvc_pkg::CordicStagesDef
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // current_x, current_y, current_yaw, goal_x, goal_y, goal_yaw
    input  wire logic [95:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // linear_speed, turn_rate
    output logic [63:0]      o_m_tdata,
    // saturated
    output logic             o_m_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [ppvc_pkg::AddrW-1:0] i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int NCells = (CORDIC_STAGES > ppvc_pkg::SqrtSteps) ?
                            CORDIC_STAGES : ppvc_pkg::SqrtSteps;
    localparam int Depth  = NCells + 3;

    logic               w_en;
    logic [Depth-1:0]   r_vld;
    logic signed [15:0] r_gd, r_gb, r_gh;
    ppvc_pkg::t_cell    w_cell [NCells+1];

    // gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gd <= 16'sd768;
            r_gb <= 16'sd2048;
            r_gh <= -16'sd384;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ppvc_pkg::RegGainDistance: r_gd <= i_cfg_wdata;
                ppvc_pkg::RegGainBearing:  r_gb <= i_cfg_wdata;
                ppvc_pkg::RegGainHeading:  r_gh <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipe advance and valid chain
    assign w_en       = !r_vld[Depth-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Depth-2:0], i_s_tvalid};
        end
    end

    ppvc_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (i_s_tdata),
        .o_cell (w_cell[0])
    );

    // row of cells
    for (genvar g = 0; g < NCells; g++) begin : g_cell
        ppvc_cell #(
            .IDX    (g),
            .STAGES (CORDIC_STAGES)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cell (w_cell[g]),
            .o_cell (w_cell[g+1])
        );
    end

    ppvc_post u_post (
        .i_clk           (i_clk),
        .i_en            (w_en),
        .i_cell          (w_cell[NCells]),
        .i_gain_distance (r_gd),
        .i_gain_bearing  (r_gb),
        .i_gain_heading  (r_gh),
        .o_data          (o_m_tdata),
        .o_sat           (o_m_tuser)
    );

endmodule
`default_nettype wire

/* dv/tb_polar_pose_velocity_controller.sv */
`timescale 1ns / 1ps
module tb_polar_pose_velocity_controller;

    localparam int Stages     = 16;
    localparam int DrainWait  = 40;
    localparam int StuckLimit = 4000;

    typedef struct {
        logic signed [15:0] cx, cy, cyaw, gx, gy, gyaw;
    } t_pose_pair;

    typedef struct {
        logic signed [31:0] speed;
        logic signed [31:0] turn;
        logic               sat;
    } t_velocity;

    typedef struct {
        t_pose_pair pose;
        bit         typed;
        t_velocity  vel;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic        o_m_tuser;
    logic        i_cfg_we = 1'b0;
    logic [ppvc_pkg::AddrW-1:0] i_cfg_addr = '0;
    logic [15:0] i_cfg_wdata = '0;

    // gains as the block should hold them
    logic signed [15:0] k_dist = 16'sd768;
    logic signed [15:0] k_bear = 16'sd2048;
    logic signed [15:0] k_head = -16'sd384;

    t_velocity velocity_q[$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        stuck = 0;

    always #2 i_clk = ~i_clk;

    polar_pose_velocity_controller #(.CORDIC_STAGES(Stages)) u_dut (.*);

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 42;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // cordic vectoring, angle returned in q3.13
    function automatic longint bearing_of(longint dx, longint dy);
        longint x = dx * 65536;
        longint y = dy * 65536;
        longint z = 0;
        longint t, xs, ys;
        if (dx == 0 && dy == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = 26353589;
            end else begin
                x = -y; y = t; z = -26353589;
            end
        end
        for (int i = 0; i < Stages && i < ppvc_pkg::AtanLen; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(ppvc_pkg::atan_entry(i));
            end else begin
                x -= ys; y += xs; z -= longint'(ppvc_pkg::atan_entry(i));
            end
        end
        return (z + 1024) >>> 11;
    endfunction

    function automatic longint clip32(longint v, inout logic flag);
        if (v > 64'sd2147483647) begin flag = 1'b1; return 64'sd2147483647; end
        if (v < -64'sd2147483648) begin flag = 1'b1; return -64'sd2147483648; end
        return v;
    endfunction

    function automatic t_velocity steer(t_pose_pair p);
        t_velocity r;
        longint dx, dy, dth, rho, alpha, beta, v, w;
        logic f = 1'b0;
        dx = longint'(p.gx) - longint'(p.cx);
        dy = longint'(p.gy) - longint'(p.cy);
        dth = longint'(p.gyaw) - longint'(p.cyaw);
        rho = longint'(root_floor(longint'(dx * dx + dy * dy) << 8));
        alpha = -dth + bearing_of(dx, dy);
        beta = -dth - alpha;
        v = (longint'(k_dist) * rho + 128) >>> 8;
        w = (longint'(k_bear) * alpha + longint'(k_head) * beta + 16) >>> 5;
        r.speed = 32'(clip32(v, f));
        r.turn = 32'(clip32(w, f));
        r.sat = f;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // one request on the pose stream
    task automatic send_pose(t_pose_pair p, bit typed, t_velocity want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {p.gyaw, p.gy, p.gx, p.cyaw, p.cy, p.cx};
        do @(posedge i_clk); while (!o_s_tready);
        velocity_q.push_back(typed ? want : steer(p));
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (velocity_q.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_gain(logic [ppvc_pkg::AddrW-1:0] idx, logic [15:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ppvc_pkg::RegGainDistance: k_dist = val;
            ppvc_pkg::RegGainBearing:  k_bear = val;
            ppvc_pkg::RegGainHeading:  k_head = val;
            default: ;
        endcase
    endtask

    function automatic t_pose_pair random_pose(bit near);
        t_pose_pair p;
        p.cx = 16'($urandom); p.cy = 16'($urandom); p.cyaw = 16'($urandom);
        p.gx = 16'($urandom); p.gy = 16'($urandom); p.gyaw = 16'($urandom);
        // short distances and yaw errors, as in normal tracking
        if (near) begin
            p.gx = p.cx + 16'($signed($urandom_range(0, 511)) - 256);
            p.gy = p.cy + 16'($signed($urandom_range(0, 511)) - 256);
            p.gyaw = p.cyaw + 16'($signed($urandom_range(0, 4095)) - 2048);
        end
        return p;
    endfunction

    // result checking
    always @(posedge i_clk) begin
        t_velocity e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (velocity_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                e = velocity_q.pop_front();
                if ($signed(o_m_tdata[31:0]) != e.speed)
                    report("linear_speed", $signed(o_m_tdata[31:0]), e.speed);
                if ($signed(o_m_tdata[63:32]) != e.turn)
                    report("turn_rate", $signed(o_m_tdata[63:32]), e.turn);
                if (o_m_tuser != e.sat)
                    report("saturated", o_m_tuser, e.sat);
            end
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog on handshake progress
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stuck <= 0;
        end else if (stuck >= StuckLimit) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_velocity none;
        int phase_idle[4] = '{0, 76, 0, 15};
        int phase_stall[4] = '{0, 0, 76, 15};

        none = '{speed: 0, turn: 0, sat: 0};
        // coincident positions, no yaw error
        rows.push_back('{'{0, 0, 0, 0, 0, 0}, 1, none});
        // coincident positions, goal turned by one radian
        rows.push_back('{'{100, -50, 0, 100, -50, 8192}, 1, '{0, -524288, 0}});
        rows.push_back('{'{-32768, -32768, -32768, 32767, 32767, 32767}, 0, none});
        rows.push_back('{'{32767, 32767, 32767, -32768, -32768, -32768}, 0, none});
        rows.push_back('{'{32767, -32768, 0, -32768, 32767, 0}, 0, none});
        rows.push_back('{'{-32768, 32767, 0, 32767, -32768, 0}, 0, none});
        // left half plane with dy positive, zero and negative
        rows.push_back('{'{0, 0, 100, -4096, 10, -100}, 0, none});
        rows.push_back('{'{0, 0, 0, -4096, 0, 0}, 0, none});
        rows.push_back('{'{0, 0, 0, -4096, -10, 0}, 0, none});
        // on the axes, then a diagonal step with extreme yaws
        rows.push_back('{'{0, 0, 0, 4096, 0, 0}, 0, none});
        rows.push_back('{'{0, 0, 0, 0, 4096, 0}, 0, none});
        rows.push_back('{'{0, 0, 0, 0, -4096, 0}, 0, none});
        rows.push_back('{'{0, 0, -32768, 1, 1, 32767}, 0, none});

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            r = rows[i];
            send_pose(r.pose, r.typed, r.vel);
        end
        drain();

        for (int g = 0; g < 5; g++) begin
            case (g)
                0: begin
                    write_gain(ppvc_pkg::RegGainDistance, 16'h7fff);
                    write_gain(ppvc_pkg::RegGainBearing, 16'h7fff);
                    write_gain(ppvc_pkg::RegGainHeading, 16'h7fff);
                end
                1: begin
                    write_gain(ppvc_pkg::RegGainDistance, 16'h8000);
                    write_gain(ppvc_pkg::RegGainBearing, 16'h8000);
                    write_gain(ppvc_pkg::RegGainHeading, 16'h8000);
                end
                2: begin
                    write_gain(ppvc_pkg::RegGainDistance, 16'h0000);
                    write_gain(ppvc_pkg::RegGainBearing, 16'h0000);
                    // unused index, ignored by the block
                    write_gain(2'd3, 16'h1234);
                end
                default: begin
                    write_gain(ppvc_pkg::RegGainDistance, 16'($urandom));
                    write_gain(ppvc_pkg::RegGainBearing, 16'($urandom));
                    write_gain(ppvc_pkg::RegGainHeading, 16'($urandom));
                end
            endcase
            for (int ph = 0; ph < 4; ph++) begin
                send_idle_pct = phase_idle[ph];
                stall_pct = phase_stall[ph];
                for (int n = 0; n < 65; n++) begin
                    send_pose(random_pose($urandom_range(99) < 70), 0, none);
                    // hold off until the pipe is empty
                    if (n == 30 && ph == 1) begin
                        i_s_tvalid <= 1'b0;
                        while (velocity_q.size() != 0) @(posedge i_clk);
                    end
                end
            end
            send_idle_pct = 0;
            stall_pct = 0;
            drain();
        end

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* polar_pose_velocity_controller.f */
sv/ppvc_pkg.sv
sv/ppvc_prep.sv
sv/ppvc_cell.sv
sv/ppvc_post.sv
sv/polar_pose_velocity_controller.sv
dv/tb_polar_pose_velocity_controller.sv
